### design/vcl_pkg.sv
// ----------------------------------------------------------------------------
// Voronoi cell labeler package
// Shared types, field widths and codes for the nearest-seed labeler.
// ----------------------------------------------------------------------------
package vcl_pkg;

  localparam int CmdW      = 2;
  localparam int StatusW   = 2;
  localparam int CoordW    = 8;
  localparam int CoordBits = 8;
  localparam int OwnerW    = 4;
  localparam int HeightW   = 8;
  localparam int DistW     = 33;
  localparam int CfgW      = 8;
  localparam int CfgIdxW   = 2;

  // Default seed table depth.
  localparam int DefMaxSeeds = 16;

  // Coordinates wrap to CoordBits bits before use.
  localparam logic [CoordW-1:0] CoordMask =
    (CoordBits >= CoordW) ? {CoordW{1'b1}} : CoordW'((1 << CoordBits) - 1);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegMaxHeight = 2'd0;
  localparam logic [CfgIdxW-1:0] RegUnitWidth = 2'd1;
  localparam logic [CfgIdxW-1:0] RegUnitDepth = 2'd2;

  typedef enum logic [CmdW-1:0] {
    CmdLoad    = 2'd0,
    CmdMeasure = 2'd1,
    CmdShade   = 2'd2,
    CmdClear   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  // Decoded command as it waits in the queue.
  typedef struct packed {
    cmd_e              cmd;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } op_t;

  // Configuration register values.
  typedef struct packed {
    logic [CfgW-1:0] max_height;
    logic [CfgW-1:0] unit_width;
    logic [CfgW-1:0] unit_depth;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    status_e            status;
    logic [OwnerW-1:0]  owner;
    logic [HeightW-1:0] height;
    logic [DistW-1:0]   sq_dist;
  } res_t;

endpackage

### design/vcl_if.sv
// ----------------------------------------------------------------------------
// Voronoi cell labeler channels
// Valid/ready interfaces for the command and result channels.
// ----------------------------------------------------------------------------
interface vcl_in_if;
  logic                      valid;
  logic                      ready;
  logic [vcl_pkg::CmdW-1:0]   cmd;
  logic [vcl_pkg::CoordW-1:0] coord_x;
  logic [vcl_pkg::CoordW-1:0] coord_y;

  modport source (output valid, cmd, coord_x, coord_y, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, output ready);
endinterface

interface vcl_out_if;
  logic                       valid;
  logic                       ready;
  logic [vcl_pkg::StatusW-1:0] status;
  logic [vcl_pkg::OwnerW-1:0]  owner;
  logic [vcl_pkg::HeightW-1:0] height;
  logic [vcl_pkg::DistW-1:0]   scaled_sq_dist;

  modport source (output valid, status, owner, height, scaled_sq_dist, input ready);
  modport sink   (input valid, status, owner, height, scaled_sq_dist, output ready);
endinterface

### design/vcl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vcl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/vcl_front.sv
// ----------------------------------------------------------------------------
// Voronoi cell labeler front end
// Accepts commands, decodes and wraps coordinates, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module vcl_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  vcl_in_if.sink       in_i,
  output logic         op_valid_o,
  output vcl_pkg::op_t op_o,
  input  logic         op_pop_i
);
  import vcl_pkg::*;

  op_t        fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;
  op_t        op_in;

  // Decode the incoming transaction.
  always_comb begin
    op_in.cmd = cmd_e'(in_i.cmd);
    op_in.x   = in_i.coord_x & CoordMask;
    op_in.y   = in_i.coord_y & CoordMask;
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = fifo_q[rptr_q];

  // Queue payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= op_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (op_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(op_pop_i);
    end
  end

endmodule

### design/vcl_back.sv
// ----------------------------------------------------------------------------
// Voronoi cell labeler back end
// Executes queued commands: seed table updates, nearest-seed scan, scaled
// distance, region maximum update and the binary height search.
// ----------------------------------------------------------------------------
module vcl_back #(
  parameter int MaxSeeds = vcl_pkg::DefMaxSeeds
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vcl_pkg::cfg_t cfg_i,
  input  logic          op_valid_i,
  input  vcl_pkg::op_t  op_i,
  output logic          op_pop_o,
  output logic          res_valid_o,
  output vcl_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import vcl_pkg::*;

  localparam int IW = (MaxSeeds > 1) ? $clog2(MaxSeeds) : 1;
  localparam int CW = $clog2(MaxSeeds + 1);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SScan   = 4'd1;
  localparam logic [3:0] SScale  = 4'd2;
  localparam logic [3:0] SSquare = 4'd3;
  localparam logic [3:0] SEval   = 4'd4;
  localparam logic [3:0] SRhsA   = 4'd5;
  localparam logic [3:0] SRhsB   = 4'd6;
  localparam logic [3:0] SK2     = 4'd7;
  localparam logic [3:0] SKa     = 4'd8;
  localparam logic [3:0] SKb     = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [MaxSeeds-1:0] vld_q, vld_d;
  cmd_e                cmd_q, cmd_d;
  logic [CoordW-1:0]   x_q, x_d, y_q, y_d;

  // Scan pipeline.
  logic [CW-1:0]     scan_q, scan_d;
  logic              v0_q, v0_d, v1_q, v1_d;
  logic [IW-1:0]     idx0_q, idx0_d, idx1_q, idx1_d;
  logic [16:0]       d1_q, d1_d;
  logic [CoordW-1:0] dx1_q, dx1_d, dy1_q, dy1_d;
  logic [16:0]       best_d_q, best_d_d;
  logic [IW-1:0]     best_q, best_d;
  logic [CoordW-1:0] bdx_q, bdx_d, bdy_q, bdy_d;
  logic              issuing;
  logic [CoordW-1:0] dx0, dy0, sx0, sy0;

  // Distance and height search.
  logic [15:0]       sx_q, sx_d, sy_q, sy_d, mh2_q, mh2_d, k2_q, k2_d;
  logic [DistW-1:0]  d2_q, d2_d, maxd_q, maxd_d;
  logic [48:0]       rhs_q, rhs_d;
  logic [32:0]       plo_q, plo_d;
  logic [31:0]       phi_q, phi_d;
  logic [15:0]       mul_a;
  logic [DistW-1:0]  mul_b;
  logic [48:0]       prod;
  logic [2:0]        bit_q, bit_d;
  logic [7:0]        h_q, h_d, cand_q, cand_d, cand;

  // Output register.
  logic res_v_q, res_v_d;
  res_t res_q, res_d;
  logic out_free;

  // Memories.
  logic              seed_we;
  logic [15:0]       seed_rdata;
  logic              reg_we;
  logic [DistW-1:0]  reg_rdata;

  vcl_ram #(.Width(16), .Depth(MaxSeeds)) u_seed_ram (
    .clk_i  (clk_i),
    .we_i   (seed_we),
    .waddr_i(count_q[IW-1:0]),
    .wdata_i({x_q, y_q}),
    .raddr_i(scan_q[IW-1:0]),
    .rdata_o(seed_rdata)
  );

  vcl_ram #(.Width(DistW), .Depth(MaxSeeds)) u_region_ram (
    .clk_i  (clk_i),
    .we_i   (reg_we),
    .waddr_i(best_q),
    .wdata_i(d2_q),
    .raddr_i(best_q),
    .rdata_o(reg_rdata)
  );

  assign out_free    = !res_v_q || res_ready_i;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
  assign issuing     = (scan_q < count_q);

  // Stage one of the scan: grid distance to the seed just read.
  assign sx0 = seed_rdata[15:8];
  assign sy0 = seed_rdata[7:0];
  assign dx0 = (x_q >= sx0) ? x_q - sx0 : sx0 - x_q;
  assign dy0 = (y_q >= sy0) ? y_q - sy0 : sy0 - y_q;

  // Shared split multiplier for the height search.
  assign mul_a = (state_q == SRhsA) ? mh2_q : k2_q;
  assign mul_b = (state_q == SRhsA) ? d2_q : maxd_q;
  assign prod  = {16'd0, plo_q} + {phi_q, 17'd0};
  assign cand  = h_q | (8'd1 << bit_q);

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    vld_d    = vld_q;
    cmd_d    = cmd_q;
    x_d      = x_q;
    y_d      = y_q;
    scan_d   = scan_q;
    v0_d     = 1'b0;
    v1_d     = v0_q;
    idx0_d   = scan_q[IW-1:0];
    idx1_d   = idx0_q;
    d1_d     = 17'({8'd0, dx0} * {8'd0, dx0}) + 17'({8'd0, dy0} * {8'd0, dy0});
    dx1_d    = dx0;
    dy1_d    = dy0;
    best_d_d = best_d_q;
    best_d   = best_q;
    bdx_d    = bdx_q;
    bdy_d    = bdy_q;
    sx_d     = sx_q;
    sy_d     = sy_q;
    mh2_d    = mh2_q;
    d2_d     = d2_q;
    maxd_d   = maxd_q;
    rhs_d    = rhs_q;
    plo_d    = 33'(mul_a * mul_b[16:0]);
    phi_d    = 32'(mul_a * mul_b[32:17]);
    k2_d     = k2_q;
    bit_d    = bit_q;
    h_d      = h_q;
    cand_d   = cand_q;
    res_v_d  = res_v_q && !res_ready_i;
    res_d    = res_q;
    op_pop_o = 1'b0;
    seed_we  = 1'b0;
    reg_we   = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (op_valid_i && out_free) begin
          op_pop_o = 1'b1;
          cmd_d    = op_i.cmd;
          x_d      = op_i.x;
          y_d      = op_i.y;
          res_d    = '{status: StOk, owner: '0, height: '0, sq_dist: '0};
          unique case (op_i.cmd)
            CmdLoad: begin
              state_d = SScan;
              scan_d  = '0;
              // Completed in the scan state once the coordinates are registered.
            end
            CmdClear: begin
              count_d = '0;
              vld_d   = '0;
              res_v_d = 1'b1;
            end
            default: begin
              if (count_q == '0) begin
                res_d.status = StEmpty;
                res_v_d      = 1'b1;
              end else begin
                state_d = SScan;
                scan_d  = '0;
              end
            end
          endcase
        end
      end
      SScan: begin
        if (cmd_q == CmdLoad) begin
          // Append the seed unless the table is full.
          if (count_q == CW'(MaxSeeds)) begin
            res_d.status = StFull;
          end else begin
            seed_we = 1'b1;
            count_d = count_q + 1'b1;
          end
          res_v_d = 1'b1;
          state_d = SIdle;
        end else begin
          if (issuing) begin
            scan_d = scan_q + 1'b1;
            v0_d   = 1'b1;
          end
          // Stage two: keep the strictly nearest seed.
          if (v1_q && ((idx1_q == '0) || (d1_q < best_d_q))) begin
            best_d_d = d1_q;
            best_d   = idx1_q;
            bdx_d    = dx1_q;
            bdy_d    = dy1_q;
          end
          if (!issuing && !v0_q && !v1_q) begin
            state_d = SScale;
          end
        end
      end
      SScale: begin
        sx_d    = 16'(bdx_q * cfg_i.unit_width);
        sy_d    = 16'(bdy_q * cfg_i.unit_depth);
        mh2_d   = 16'(cfg_i.max_height * cfg_i.max_height);
        state_d = SSquare;
      end
      SSquare: begin
        d2_d    = 33'({16'd0, sx_q} * {16'd0, sx_q}) + 33'({16'd0, sy_q} * {16'd0, sy_q});
        maxd_d  = vld_q[best_q] ? reg_rdata : '0;
        state_d = SEval;
      end
      SEval: begin
        res_d.owner   = OwnerW'(best_q);
        res_d.sq_dist = d2_q;
        if (cmd_q == CmdMeasure) begin
          if (d2_q > maxd_q) begin
            reg_we        = 1'b1;
            vld_d[best_q] = 1'b1;
          end
          res_v_d = 1'b1;
          state_d = SIdle;
        end else if (maxd_q == '0) begin
          res_v_d = 1'b1;
          state_d = SIdle;
        end else begin
          state_d = SRhsA;
        end
      end
      SRhsA: begin
        state_d = SRhsB;
      end
      SRhsB: begin
        rhs_d   = prod;
        bit_d   = 3'd7;
        h_d     = '0;
        state_d = SK2;
      end
      SK2: begin
        k2_d    = 16'(cand * cand);
        cand_d  = cand;
        state_d = SKa;
      end
      SKa: begin
        state_d = SKb;
      end
      SKb: begin
        // Keep the candidate bit if the height still fits.
        if ((cand_q <= cfg_i.max_height) && (prod <= rhs_q)) begin
          h_d = cand_q;
        end
        if (bit_q == 3'd0) begin
          res_d.height = ((cand_q <= cfg_i.max_height) && (prod <= rhs_q)) ? cand_q : h_q;
          res_v_d      = 1'b1;
          state_d      = SIdle;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = SK2;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      vld_q   <= '0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      vld_q   <= vld_d;
      v0_q    <= v0_d;
      v1_q    <= v1_d;
      res_v_q <= res_v_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    x_q      <= x_d;
    y_q      <= y_d;
    scan_q   <= scan_d;
    idx0_q   <= idx0_d;
    idx1_q   <= idx1_d;
    d1_q     <= d1_d;
    dx1_q    <= dx1_d;
    dy1_q    <= dy1_d;
    best_d_q <= best_d_d;
    best_q   <= best_d;
    bdx_q    <= bdx_d;
    bdy_q    <= bdy_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    mh2_q    <= mh2_d;
    d2_q     <= d2_d;
    maxd_q   <= maxd_d;
    rhs_q    <= rhs_d;
    plo_q    <= plo_d;
    phi_q    <= phi_d;
    k2_q     <= k2_d;
    bit_q    <= bit_d;
    h_q      <= h_d;
    cand_q   <= cand_d;
    res_q    <= res_d;
  end

endmodule

### design/voronoi_cell_labeler_unit.sv
// ----------------------------------------------------------------------------
// Voronoi cell labeler
// Nearest-seed labeling of grid cells with per-region quantized heights.
//
//   channel  | dir | transaction payload
//   ---------+-----+--------------------------------------------
//   in_i     | in  | cmd, coord_x, coord_y
//   out_o    | out | status, owner, height, scaled_sq_dist
//   cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// Measure and shade scan the N stored seeds: the scan reads one seed a cycle
// from the seed RAM. Shade then runs a height search of eight steps through
// one split multiplier, unless the region maximum is zero.
// Reset clears the seed count and the region valid bits at once; no sweep.
// A two-entry queue lets commands be accepted while a result waits.
// ----------------------------------------------------------------------------
module voronoi_cell_labeler_unit #(
  parameter int MaxSeeds = vcl_pkg::DefMaxSeeds
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  vcl_in_if.sink                       in_i,
  vcl_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [vcl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vcl_pkg::CfgW-1:0]     cfg_data_i
);
  import vcl_pkg::*;

  cfg_t cfg_q;
  logic op_valid, op_pop;
  op_t  op;
  logic res_valid;
  res_t res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_height <= 8'd6;
      cfg_q.unit_width <= 8'd4;
      cfg_q.unit_depth <= 8'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMaxHeight: cfg_q.max_height <= cfg_data_i;
        RegUnitWidth: cfg_q.unit_width <= cfg_data_i;
        RegUnitDepth: cfg_q.unit_depth <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vcl_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .op_valid_o(op_valid),
    .op_o      (op),
    .op_pop_i  (op_pop)
  );

  vcl_back #(.MaxSeeds(MaxSeeds)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(out_o.ready)
  );

  // Result channel.
  assign out_o.valid          = res_valid;
  assign out_o.status         = res.status;
  assign out_o.owner          = res.owner;
  assign out_o.height         = res.height;
  assign out_o.scaled_sq_dist = res.sq_dist;

`ifndef SYNTHESIS
  // The back end never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop |-> op_valid) else $error("pop from empty queue");

  // Error results carry no owner and no distance.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != StOk) |->
      (out_o.owner == '0) && (out_o.scaled_sq_dist == '0))
    else $error("error result with payload");

  // A nonzero height needs a nonzero distance.
  a_height_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.height != '0) |-> (out_o.scaled_sq_dist != '0))
    else $error("height without distance");
`endif

endmodule

### test/vcl_scoreboard.sv
// ----------------------------------------------------------------------------
// Voronoi cell labeler scoreboard
// Predicts each result from accepted commands and checks the block's output.
// ----------------------------------------------------------------------------
package vcl_tb_pkg;
  import vcl_pkg::*;

  class vcl_scoreboard;
    logic [CfgW-1:0]   max_height;
    logic [CfgW-1:0]   unit_width;
    logic [CfgW-1:0]   unit_depth;
    logic [CoordW-1:0] seed_x [DefMaxSeeds];
    logic [CoordW-1:0] seed_y [DefMaxSeeds];
    int unsigned       seed_count;
    logic [33:0]       region_max [DefMaxSeeds];
    res_t              expected_results [$];
    int unsigned       errors;

    function new();
      max_height = 8'd6;
      unit_width = 8'd4;
      unit_depth = 8'd4;
      seed_count = 0;
      errors = 0;
      foreach (region_max[i]) region_max[i] = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      case (idx)
        RegMaxHeight: max_height = value;
        RegUnitWidth: unit_width = value;
        RegUnitDepth: unit_depth = value;
        default: ;
      endcase
    endfunction

    // Largest h <= mh with h*h*maxd2 <= mh*mh*d2; zero when the region maximum is zero.
    function logic [HeightW-1:0] post_height(logic [63:0] d2, logic [63:0] maxd2);
      logic [63:0] rhs;
      logic [HeightW-1:0] h;
      rhs = 64'(max_height) * 64'(max_height) * d2;
      h = '0;
      if (maxd2 == 0) return '0;
      for (int k = 1; k <= max_height; k++) begin
        if (64'(k) * 64'(k) * maxd2 <= rhs) h = HeightW'(k);
        else break;
      end
      return h;
    endfunction

    // Notes an accepted command and queues the result it should produce.
    function void note_command(cmd_e cmd, logic [CoordW-1:0] cx, logic [CoordW-1:0] cy);
      res_t r;
      logic [CoordW-1:0] x, y;
      logic [63:0] best_d, d, dx, dy, d2;
      int unsigned best;
      x = cx & CoordMask;
      y = cy & CoordMask;
      r = '{status: StOk, owner: '0, height: '0, sq_dist: '0};
      case (cmd)
        CmdLoad: begin
          if (seed_count >= DefMaxSeeds) begin
            r.status = StFull;
          end else begin
            seed_x[seed_count] = x;
            seed_y[seed_count] = y;
            seed_count++;
          end
        end
        CmdClear: begin
          seed_count = 0;
          foreach (region_max[i]) region_max[i] = '0;
        end
        default: begin
          if (seed_count == 0) begin
            r.status = StEmpty;
          end else begin
            best = 0;
            best_d = 0;
            for (int i = 0; i < seed_count; i++) begin
              dx = (seed_x[i] > x) ? 64'(seed_x[i] - x) : 64'(x - seed_x[i]);
              dy = (seed_y[i] > y) ? 64'(seed_y[i] - y) : 64'(y - seed_y[i]);
              d = dx * dx + dy * dy;
              if (i == 0 || d < best_d) begin
                best_d = d;
                best = i;
              end
            end
            dx = (seed_x[best] > x) ? 64'(seed_x[best] - x) : 64'(x - seed_x[best]);
            dy = (seed_y[best] > y) ? 64'(seed_y[best] - y) : 64'(y - seed_y[best]);
            dx = dx * unit_width;
            dy = dy * unit_depth;
            d2 = dx * dx + dy * dy;
            if (cmd == CmdMeasure) begin
              if (d2 > region_max[best]) region_max[best] = d2[33:0];
            end else begin
              r.height = post_height(d2, 64'(region_max[best]));
            end
            r.owner = OwnerW'(best);
            r.sq_dist = d2[DistW-1:0];
          end
        end
      endcase
      expected_results = {expected_results, r};
    endfunction

    // Compares one result transaction against the oldest expectation.
    function void check_result(res_t act);
      res_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (act.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, act.status);
        errors++;
      end
      if (act.owner !== exp_r.owner) begin
        $display("%0t: owner expected %0d actual %0d", $time, exp_r.owner, act.owner);
        errors++;
      end
      if (act.height !== exp_r.height) begin
        $display("%0t: height expected %0d actual %0d", $time, exp_r.height, act.height);
        errors++;
      end
      if (act.sq_dist !== exp_r.sq_dist) begin
        $display("%0t: scaled_sq_dist expected %0d actual %0d", $time, exp_r.sq_dist,
                 act.sq_dist);
        errors++;
      end
    endfunction
  endclass
endpackage

### test/voronoi_cell_labeler_unit_tb.sv
// ----------------------------------------------------------------------------
// Voronoi cell labeler testbench
// Drives load, measure, shade and clear commands with random handshake gaps
// and register settings, and checks every result against a scoreboard.
// ----------------------------------------------------------------------------
module voronoi_cell_labeler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vcl_pkg::*;
  import vcl_tb_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  vcl_in_if  cmd_ch ();
  vcl_out_if res_ch ();

  vcl_scoreboard sb;
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 79;
  bit hold_results = 1'b0;
  int unsigned stalled_cycles = 0;

  voronoi_cell_labeler_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_ch.sink),
    .out_o      (res_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = '0;
    cmd_ch.coord_x = '0;
    cmd_ch.coord_y = '0;
    res_ch.ready = 1'b0;
  end

  // Result side: random ready, checks each result transaction.
  always @(negedge clk_i) begin
    if (hold_results) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      sb.check_result('{status: status_e'(res_ch.status), owner: res_ch.owner,
                        height: res_ch.height, sq_dist: res_ch.scaled_sq_dist});
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (rst_ni) begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offers one command after random idle gaps and holds it until it is accepted.
  task automatic send_command(cmd_e cmd, logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= cmd;
    cmd_ch.coord_x <= x;
    cmd_ch.coord_y <= y;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sb.note_command(cmd, x, y);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic set_regs(logic [CfgW-1:0] mh, logic [CfgW-1:0] uw, logic [CfgW-1:0] ud);
    wait_drained();
    write_reg(RegMaxHeight, mh);
    write_reg(RegUnitWidth, uw);
    write_reg(RegUnitDepth, ud);
    cfg_we_i <= 1'b0;
  endtask

  // A random run: clear, one to 17 seeds, then a random mix of measures, shades, loads and clears.
  task automatic random_scene(int unsigned n_items);
    int unsigned done;
    int unsigned n_seeds;
    int unsigned r;
    done = 0;
    send_command(CmdClear, 8'($urandom), 8'($urandom));
    n_seeds = $urandom_range(1, 17);
    for (int i = 0; i < n_seeds; i++) send_command(CmdLoad, 8'($urandom), 8'($urandom));
    done = n_seeds + 1;
    while (done < n_items) begin
      r = $urandom_range(99);
      if (r < 45) send_command(CmdMeasure, 8'($urandom), 8'($urandom));
      else if (r < 93) send_command(CmdShade, 8'($urandom), 8'($urandom));
      else if (r < 97) send_command(CmdLoad, 8'($urandom), 8'($urandom));
      else send_command(CmdClear, 8'($urandom), 8'($urandom));
      done++;
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, extremes, full table, saturation, clear.
    send_command(CmdMeasure, 8'd0, 8'd0);
    send_command(CmdShade, 8'hff, 8'hff);
    send_command(CmdLoad, 8'd0, 8'd0);
    send_command(CmdShade, 8'd10, 8'd10);
    send_command(CmdMeasure, 8'hff, 8'hff);
    send_command(CmdShade, 8'h80, 8'h80);
    send_command(CmdShade, 8'hff, 8'hff);
    for (int i = 1; i < 16; i++) send_command(CmdLoad, 8'(i * 17), 8'(255 - i * 17));
    send_command(CmdLoad, 8'h55, 8'haa);
    send_command(CmdMeasure, 8'd8, 8'd8);
    send_command(CmdShade, 8'd8, 8'd8);
    send_command(CmdClear, 8'hff, 8'hff);
    send_command(CmdShade, 8'd1, 8'd1);

    // Extreme settings, including zero height and the widest spacing.
    set_regs(8'd255, 8'd255, 8'd255);
    send_command(CmdLoad, 8'd0, 8'd0);
    send_command(CmdMeasure, 8'hff, 8'hff);
    send_command(CmdShade, 8'hff, 8'hff);
    send_command(CmdShade, 8'h7f, 8'h01);
    set_regs(8'd0, 8'd1, 8'd1);
    send_command(CmdShade, 8'hff, 8'hff);

    // Random phases, cycling through idle patterns and register settings.
    for (int p = 0; p < 9; p++) begin
      if (p == 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 30;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_regs(8'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      if (p == 1) set_regs(8'd255, 8'd1, 8'd255);
      // Long output hold-off while commands keep coming.
      if (p == 4) begin
        fork
          begin
            hold_results = 1'b1;
            repeat (400) @(negedge clk_i);
            hold_results = 1'b0;
          end
        join_none
      end
      random_scene(110);
    end
    wait_drained();
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
